FILE: design/pli_pkg.sv
`default_nettype none

package pli_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 24;
    localparam int CW       = 48;
    localparam int ANG_W    = 32;
    localparam int QW       = 16;
    localparam int IDX_W    = 18;
    localparam int CORDIC_N = 16;
    localparam int SIDE_W   = CW + 1;
    localparam int PROD_W   = COORD_W + 16;

    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [ANG_W-1:0] INCL_LIMIT = 32'sd178956970;
    localparam logic [14:0] INV_GAIN = 15'd19899;
    localparam logic [12:0] MAX_AZIM = 13'd4096;
    localparam logic [6:0]  MAX_INCL = 7'd64;

    // Register map, one 64-bit register every eight bytes.
    typedef enum logic [2:0] {
        REG_ROW_X       = 3'd0,
        REG_ROW_Y       = 3'd1,
        REG_ROW_Z       = 3'd2,
        REG_AZIM_STEP   = 3'd3,
        REG_INCL_STEP   = 3'd4,
        REG_INCL_OFFSET = 3'd5,
        REG_INCL_RAYS   = 3'd6,
        REG_AZIM_RAYS   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [15:0] azim_step;
        logic [15:0] incl_step;
        logic [14:0] incl_offset;
        logic [6:0]  incl_rays;
        logic [12:0] azim_rays;
    } cfg_t;

    // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
    function automatic logic [ANG_W-1:0] atan_turn(input int i);
        logic [ANG_W-1:0] a;
        case (i)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/pli_if.sv
`default_nettype none

// Point word: one 3D point in 1/1024 m.
interface pli_point_if;
    import pli_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    modport source (output valid, px, py, pz, input ready);
    modport sink (input valid, px, py, pz, output ready);
endinterface

// Ray word: view flag and ray index.
interface pli_ray_if;
    import pli_pkg::*;
    logic             valid;
    logic             ready;
    logic             in_view;
    logic [IDX_W-1:0] ray_index;
    modport source (output valid, in_view, ray_index, input ready);
    modport sink (input valid, in_view, ray_index, output ready);
endinterface

`default_nettype wire

FILE: design/pli_apb.sv
`default_nettype none

module pli_apb
    import pli_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase; reset gives the identity pose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_x       <= 64'd16384;
            cfg_reg.row_y       <= 64'd1073741824;
            cfg_reg.row_z       <= 64'd70368744177664;
            cfg_reg.azim_step   <= 16'd37;
            cfg_reg.incl_step   <= 16'd364;
            cfg_reg.incl_offset <= 15'd2731;
            cfg_reg.incl_rays   <= 7'd16;
            cfg_reg.azim_rays   <= 13'd1800;
        end
        else if (wr)
        begin
            case (idx)
                REG_ROW_X:       cfg_reg.row_x       <= pwdata;
                REG_ROW_Y:       cfg_reg.row_y       <= pwdata;
                REG_ROW_Z:       cfg_reg.row_z       <= pwdata;
                REG_AZIM_STEP:   cfg_reg.azim_step   <= pwdata[15:0];
                REG_INCL_STEP:   cfg_reg.incl_step   <= pwdata[15:0];
                REG_INCL_OFFSET: cfg_reg.incl_offset <= pwdata[14:0];
                REG_INCL_RAYS:   cfg_reg.incl_rays   <= pwdata[6:0];
                REG_AZIM_RAYS:   cfg_reg.azim_rays   <= pwdata[12:0];
                default:         ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (idx)
            REG_ROW_X:       prdata = cfg_reg.row_x;
            REG_ROW_Y:       prdata = cfg_reg.row_y;
            REG_ROW_Z:       prdata = cfg_reg.row_z;
            REG_AZIM_STEP:   prdata = {48'd0, cfg_reg.azim_step};
            REG_INCL_STEP:   prdata = {48'd0, cfg_reg.incl_step};
            REG_INCL_OFFSET: prdata = {49'd0, cfg_reg.incl_offset};
            REG_INCL_RAYS:   prdata = {57'd0, cfg_reg.incl_rays};
            REG_AZIM_RAYS:   prdata = {51'd0, cfg_reg.azim_rays};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/pli_transform.sv
`default_nettype none

module pli_transform
    import pli_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      vin,
    input  wire logic signed [COORD_W-1:0] px,
    input  wire logic signed [COORD_W-1:0] py,
    input  wire logic signed [COORD_W-1:0] pz,
    input  wire cfg_t                      cfg,
    output logic                           vout,
    output logic signed [CW-1:0]           x,
    output logic signed [CW-1:0]           y,
    output logic signed [CW-1:0]           z
);

    logic               vld_reg [0:1];
    logic signed [PROD_W-1:0] prod_reg [0:8];
    logic signed [15:0]   trans_reg [0:2];
    logic signed [CW-1:0] sum_reg [0:2];
    logic [63:0]          rows [0:2];
    logic signed [COORD_W-1:0] pt [0:2];

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;
    assign pt[0]   = px;
    assign pt[1]   = py;
    assign pt[2]   = pz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
            vld_reg[1] <= vld_reg[0];
        end
    end

    // First stage multiplies, second stage sums each row.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[3*r+c] <= $signed(rows[r][16*c +: 16]) * pt[c];
                end
                trans_reg[r] <= $signed(rows[r][63:48]);
            end
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= CW'(prod_reg[3*r]) + CW'(prod_reg[3*r+1])
                            + CW'(prod_reg[3*r+2])
                            + $signed({{(CW-32){trans_reg[r][15]}}, trans_reg[r], 16'h0000});
            end
        end
    end

    assign vout = vld_reg[1];
    assign x    = sum_reg[0];
    assign y    = sum_reg[1];
    assign z    = sum_reg[2];

endmodule

`default_nettype wire

FILE: design/pli_cordic.sv
`default_nettype none

module pli_cordic
    import pli_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vin,
    input  wire logic signed [CW-1:0] xin,
    input  wire logic signed [CW-1:0] yin,
    input  wire logic [ANG_W-1:0]     ang_in,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      vout,
    output logic signed [CW-1:0]      xout,
    output logic [ANG_W-1:0]          ang_out,
    output logic [SIDE_W-1:0]         side_out
);

    logic                 vld_reg  [0:CORDIC_N-1];
    logic signed [CW-1:0] x_reg    [0:CORDIC_N-1];
    logic signed [CW-1:0] y_reg    [0:CORDIC_N-1];
    logic [ANG_W-1:0]     ang_reg  [0:CORDIC_N-1];
    logic [SIDE_W-1:0]    side_reg [0:CORDIC_N-1];
    logic signed [CW-1:0] x_next   [0:CORDIC_N-1];
    logic signed [CW-1:0] y_next   [0:CORDIC_N-1];
    logic [ANG_W-1:0]     ang_next [0:CORDIC_N-1];

    // One vectoring micro-rotation per stage, turning y toward zero.
    always_comb
    begin
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic [ANG_W-1:0]     sa;
        for (int g = 0; g < CORDIC_N; g++)
        begin
            sx = (g == 0) ? xin : x_reg[(g == 0) ? 0 : g-1];
            sy = (g == 0) ? yin : y_reg[(g == 0) ? 0 : g-1];
            sa = (g == 0) ? ang_in : ang_reg[(g == 0) ? 0 : g-1];
            if (sy > 0)
            begin
                x_next[g]   = sx + (sy >>> g);
                y_next[g]   = sy - (sx >>> g);
                ang_next[g] = sa + atan_turn(g);
            end
            else
            begin
                x_next[g]   = sx - (sy >>> g);
                y_next[g]   = sy + (sx >>> g);
                ang_next[g] = sa - atan_turn(g);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < CORDIC_N; g++)
            begin
                vld_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
            for (int g = 1; g < CORDIC_N; g++)
            begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int g = 0; g < CORDIC_N; g++)
            begin
                x_reg[g]   <= x_next[g];
                y_reg[g]   <= y_next[g];
                ang_reg[g] <= ang_next[g];
                if (g > 0)
                begin
                    side_reg[g] <= side_reg[(g > 0) ? g-1 : 0];
                end
            end
        end
    end

    assign vout     = vld_reg[CORDIC_N-1];
    assign xout     = x_reg[CORDIC_N-1];
    assign ang_out  = ang_reg[CORDIC_N-1];
    assign side_out = side_reg[CORDIC_N-1];

endmodule

`default_nettype wire

FILE: design/pli_divider.sv
`default_nettype none

module pli_divider
    import pli_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [QW-1:0] a_dvd,
    input  wire logic [QW-1:0] a_dvs,
    input  wire logic [QW-1:0] b_dvd,
    input  wire logic [QW-1:0] b_dvs,
    input  wire logic          flag_in,
    output logic               vout,
    output logic [QW-1:0]      a_quo,
    output logic [QW-1:0]      b_quo,
    output logic               flag_out
);

    logic          vld_reg  [0:QW-1];
    logic          flag_reg [0:QW-1];
    logic [QW-1:0] ad_reg   [0:QW-1];
    logic [QW-1:0] ar_reg   [0:QW-1];
    logic [QW-1:0] aq_reg   [0:QW-1];
    logic [QW-1:0] bd_reg   [0:QW-1];
    logic [QW-1:0] br_reg   [0:QW-1];
    logic [QW-1:0] bq_reg   [0:QW-1];
    logic [QW-1:0] ar_next  [0:QW-1];
    logic [QW-1:0] aq_next  [0:QW-1];
    logic [QW-1:0] br_next  [0:QW-1];
    logic [QW-1:0] bq_next  [0:QW-1];

    // Restoring division, one quotient bit per stage, MSB first, two lanes.
    always_comb
    begin
        logic [QW:0]   ra;
        logic [QW:0]   rb;
        logic [QW-1:0] da;
        logic [QW-1:0] db;
        for (int g = 0; g < QW; g++)
        begin
            da = (g == 0) ? a_dvd : ad_reg[(g == 0) ? 0 : g-1];
            db = (g == 0) ? b_dvd : bd_reg[(g == 0) ? 0 : g-1];
            ra = {((g == 0) ? '0 : ar_reg[(g == 0) ? 0 : g-1]), da[QW-1-g]};
            rb = {((g == 0) ? '0 : br_reg[(g == 0) ? 0 : g-1]), db[QW-1-g]};
            aq_next[g] = (g == 0) ? '0 : aq_reg[(g == 0) ? 0 : g-1];
            bq_next[g] = (g == 0) ? '0 : bq_reg[(g == 0) ? 0 : g-1];
            if (ra >= {1'b0, a_dvs})
            begin
                ra = ra - {1'b0, a_dvs};
                aq_next[g][QW-1-g] = 1'b1;
            end
            if (rb >= {1'b0, b_dvs})
            begin
                rb = rb - {1'b0, b_dvs};
                bq_next[g][QW-1-g] = 1'b1;
            end
            ar_next[g] = ra[QW-1:0];
            br_next[g] = rb[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < QW; g++)
            begin
                vld_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
            for (int g = 1; g < QW; g++)
            begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_reg[0]   <= a_dvd;
            bd_reg[0]   <= b_dvd;
            flag_reg[0] <= flag_in;
            for (int g = 0; g < QW; g++)
            begin
                ar_reg[g] <= ar_next[g];
                aq_reg[g] <= aq_next[g];
                br_reg[g] <= br_next[g];
                bq_reg[g] <= bq_next[g];
                if (g > 0)
                begin
                    ad_reg[g]   <= ad_reg[(g > 0) ? g-1 : 0];
                    bd_reg[g]   <= bd_reg[(g > 0) ? g-1 : 0];
                    flag_reg[g] <= flag_reg[(g > 0) ? g-1 : 0];
                end
            end
        end
    end

    assign vout     = vld_reg[QW-1];
    assign a_quo    = aq_reg[QW-1];
    assign b_quo    = bq_reg[QW-1];
    assign flag_out = flag_reg[QW-1];

endmodule

`default_nettype wire

FILE: design/point_to_lidar_ray_index.sv
`default_nettype none
// Stages: transform, fold, azimuth CORDIC, gain, inclination CORDIC, window,
// divider, output. Throughput: one word per cycle; the two 16-stage CORDIC
// pipelines and 16-stage divider each take a new word every cycle unless held.
// The whole pipeline advances together and holds while the output word waits.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the
// identity pose and default ray geometry into the registers.

module point_to_lidar_ray_index
    import pli_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    pli_point_if.sink        pts,
    pli_ray_if.source        rays
);

    cfg_t cfg;
    logic en;

    logic                 t_vld;
    logic signed [CW-1:0] t_x, t_y, t_z;

    logic                 c_vld_reg;
    logic                 c_zero_reg;
    logic signed [CW-1:0] c_x_reg, c_y_reg, c_z_reg;
    logic [ANG_W-1:0]     c_ang_reg;

    logic                 k1_vld;
    logic signed [CW-1:0] k1_x;
    logic [ANG_W-1:0]     k1_ang;
    logic [SIDE_W-1:0]    k1_side;

    logic                 d_vld_reg;
    logic                 d_zero_reg;
    logic signed [CW-1:0] d_r_reg, d_z_reg;
    logic [QW-1:0]        d_az_reg;
    logic [CW-1:0]        r_next;

    logic                 k2_vld;
    logic signed [CW-1:0] k2_x;
    logic [ANG_W-1:0]     k2_ang;
    logic [SIDE_W-1:0]    k2_side;

    logic                 e_vld_reg;
    logic                 e_oob_reg;
    logic [QW-1:0]        e_az_reg, e_incl_reg;
    logic signed [ANG_W-1:0] incl32;
    logic signed [17:0]   shifted;

    logic                 q_vld;
    logic [QW-1:0]        q_abin, q_ibin;
    logic                 q_oob;

    logic [QW-1:0]        astep, istep;
    logic [12:0]          nazim;
    logic [6:0]           nincl;
    logic                 f_bad;
    logic [QW-1:0]        abin_w;
    logic [QW+6:0]        idx_full;

    logic                 out_vld_reg;
    logic                 in_view_reg;
    logic [IDX_W-1:0]     idx_reg;

    // The pipeline moves unless the output word is held.
    assign en        = !out_vld_reg || rays.ready;
    assign pts.ready = en;

    pli_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pli_transform u_xform (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (pts.valid),
        .px    (pts.px),
        .py    (pts.py),
        .pz    (pts.pz),
        .cfg   (cfg),
        .vout  (t_vld),
        .x     (t_x),
        .y     (t_y),
        .z     (t_z)
    );

    // Fold the left half-plane into the right one before azimuth CORDIC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= t_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_zero_reg <= (t_x == 0) && (t_y == 0) && (t_z == 0);
            c_z_reg    <= t_z;
            if (t_x < 0)
            begin
                c_x_reg   <= -t_x;
                c_y_reg   <= -t_y;
                c_ang_reg <= HALF_TURN;
            end
            else
            begin
                c_x_reg   <= t_x;
                c_y_reg   <= t_y;
                c_ang_reg <= '0;
            end
        end
    end

    pli_cordic u_azim (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (c_vld_reg),
        .xin      (c_x_reg),
        .yin      (c_y_reg),
        .ang_in   (c_ang_reg),
        .side_in  ({c_zero_reg, c_z_reg}),
        .vout     (k1_vld),
        .xout     (k1_x),
        .ang_out  (k1_ang),
        .side_out (k1_side)
    );

    // Remove the CORDIC gain from the horizontal length; truncating product.
    assign r_next = 48'(k1_x[CW-1:15] * INV_GAIN)
                  + 48'((30'(k1_x[14:0]) * 30'(INV_GAIN)) >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= k1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_r_reg    <= $signed(r_next);
            d_z_reg    <= $signed(k1_side[CW-1:0]);
            d_zero_reg <= k1_side[CW];
            d_az_reg   <= QW'((k1_ang + HALF_TURN) >> 16);
        end
    end

    pli_cordic u_incl (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (d_vld_reg),
        .xin      (d_r_reg),
        .yin      (d_z_reg),
        .ang_in   ('0),
        .side_in  ({d_zero_reg, {(CW-QW){1'b0}}, d_az_reg}),
        .vout     (k2_vld),
        .xout     (k2_x),
        .ang_out  (k2_ang),
        .side_out (k2_side)
    );

    // Inclination window and offset; a negative shifted angle is out of view.
    assign incl32  = $signed(k2_ang);
    assign shifted = 18'(incl32 >>> 16) + $signed({3'b000, cfg.incl_offset});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= k2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_oob_reg  <= k2_side[CW] || (incl32 > INCL_LIMIT) || (incl32 < -INCL_LIMIT)
                          || shifted[17];
            e_az_reg   <= k2_side[QW-1:0];
            e_incl_reg <= shifted[QW-1:0];
        end
    end

    assign astep = (cfg.azim_step == 0) ? QW'(1) : cfg.azim_step;
    assign istep = (cfg.incl_step == 0) ? QW'(1) : cfg.incl_step;

    pli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (e_vld_reg),
        .a_dvd    (e_az_reg),
        .a_dvs    (astep),
        .b_dvd    (e_incl_reg),
        .b_dvs    (istep),
        .flag_in  (e_oob_reg),
        .vout     (q_vld),
        .a_quo    (q_abin),
        .b_quo    (q_ibin),
        .flag_out (q_oob)
    );

    // Bin range checks, azimuth wrap and index composition.
    assign nazim    = (cfg.azim_rays > MAX_AZIM) ? MAX_AZIM : cfg.azim_rays;
    assign nincl    = (cfg.incl_rays > MAX_INCL) ? MAX_INCL : cfg.incl_rays;
    assign f_bad    = q_oob || (q_ibin >= QW'(nincl)) || (nazim == 0)
                      || (q_abin > QW'(nazim));
    assign abin_w   = (q_abin == QW'(nazim)) ? '0 : q_abin;
    assign idx_full = (QW+7)'(abin_w * nincl) + (QW+7)'(q_ibin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_view_reg <= !f_bad;
            idx_reg     <= f_bad ? '0 : idx_full[IDX_W-1:0];
        end
    end

    assign rays.valid     = out_vld_reg;
    assign rays.in_view   = in_view_reg;
    assign rays.ray_index = idx_reg;

`ifndef SYNTHESIS
    // An out-of-view word always carries index zero.
    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !in_view_reg |-> idx_reg == 0)
        else $error("out-of-view word with nonzero index");

    // A held output word keeps the input side closed.
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !rays.ready |-> !pts.ready)
        else $error("input accepted while output word is held");

    // A stall keeps the last stage valid bit.
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !rays.ready |=> out_vld_reg)
        else $error("held output word dropped");

    // An in-view word always comes from an in-view inclination bin.
    a_incl_bin: assert property (@(posedge clk) disable iff (!rst_n)
        en && q_vld && !f_bad |-> q_ibin < QW'(nincl))
        else $error("inclination bin out of range marked in view");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
    import pli_pkg::*;

    localparam int  PIPE_WAIT  = 70;
    localparam int  PHASE_PTS  = 320;
    localparam int  NUM_PHASES = 5;
    localparam longint CYCLE_LIMIT = 400000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_STEP [16] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct packed {
        logic             in_view;
        logic [IDX_W-1:0] ray_index;
    } ray_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        bit                        known;
        ray_word_t                 word;
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    pli_point_if pts ();
    pli_ray_if   rays ();

    point_to_lidar_ray_index dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pts     (pts),
        .rays    (rays)
    );

    cfg_t        geom;
    ray_word_t   pending_rays[$];
    int          errors;
    int          rays_seen;
    int          rays_hit;
    int          points_sent;
    longint      cycles = 0;
    bit          quiet;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    // One transform row applied to a point, in units of 2^-14/1024 m.
    function automatic longint apply_row(logic [63:0] row, longint a, longint b, longint c);
        return longint'($signed(row[15:0])) * a + longint'($signed(row[31:16])) * b
             + longint'($signed(row[47:32])) * c + longint'($signed(row[63:48])) * 65536;
    endfunction

    // Vectoring rotation: drives vy to zero and returns the angle turned.
    function automatic logic [31:0] rotate_to_axis(inout longint vx, inout longint vy);
        logic [31:0] ang;
        longint      dx;
        longint      dy;
        ang = '0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx += dx;
                vy -= dy;
                ang += ATAN_STEP[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                ang -= ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    // Expected ray word for one point under the current geometry.
    function automatic ray_word_t project_point(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b,
                                                logic signed [COORD_W-1:0] c);
        ray_word_t         w;
        longint            x;
        longint            y;
        longint            z;
        longint            rr;
        longint unsigned   rk;
        logic [31:0]       ang;
        logic [15:0]       az16;
        int                incl32;
        longint            shifted;
        longint unsigned   ibin;
        longint unsigned   abin;
        int unsigned       nazim;
        int unsigned       nincl;
        int unsigned       astep;
        int unsigned       istep;
        w = '0;
        x = apply_row(geom.row_x, a, b, c);
        y = apply_row(geom.row_y, a, b, c);
        z = apply_row(geom.row_z, a, b, c);
        nazim = (geom.azim_rays > MAX_AZIM) ? MAX_AZIM : geom.azim_rays;
        nincl = (geom.incl_rays > MAX_INCL) ? MAX_INCL : geom.incl_rays;
        astep = (geom.azim_step == 0) ? 1 : geom.azim_step;
        istep = (geom.incl_step == 0) ? 1 : geom.incl_step;
        if (x == 0 && y == 0 && z == 0)
            return w;
        ang = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = HALF_TURN;
        end
        ang += rotate_to_axis(x, y);
        ang = ang + HALF_TURN;
        az16 = ang[31:16];
        // Horizontal length, scaled back by the inverse rotation gain.
        rk = longint'(x);
        rr = longint'((rk >> 15) * 19899 + (((rk & 64'h7FFF) * 19899) >> 15));
        ang = rotate_to_axis(rr, z);
        incl32 = int'(ang);
        if (incl32 > INCL_LIMIT || incl32 < -INCL_LIMIT)
            return w;
        shifted = longint'(incl32 >>> 16) + longint'(geom.incl_offset);
        if (shifted < 0)
            return w;
        ibin = longint'(shifted) / istep;
        if (ibin >= nincl)
            return w;
        abin = az16 / astep;
        if (nazim == 0 || abin > nazim)
            return w;
        if (abin == nazim)
            abin = 0;
        w.in_view = 1'b1;
        w.ray_index = IDX_W'(abin * nincl + ibin);
        return w;
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(reg_idx_t r, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_ROW_X:       geom.row_x = v;
            REG_ROW_Y:       geom.row_y = v;
            REG_ROW_Z:       geom.row_z = v;
            REG_AZIM_STEP:   geom.azim_step = v[15:0];
            REG_INCL_STEP:   geom.incl_step = v[15:0];
            REG_INCL_OFFSET: geom.incl_offset = v[14:0];
            REG_INCL_RAYS:   geom.incl_rays = v[6:0];
            default:         geom.azim_rays = v[12:0];
        endcase
    endtask

    // Waits until every expected ray word has come and the pipeline is empty.
    task automatic drain_pipeline();
        while (pending_rays.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    // Sends one point word, with a random gap first unless quiet.
    task automatic send_point(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b,
                              logic signed [COORD_W-1:0] c, bit known, ray_word_t w);
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            pts.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        pts.valid <= 1'b1;
        pts.px    <= a;
        pts.py    <= b;
        pts.pz    <= c;
        @(posedge clk);
        while (!pts.ready)
            @(posedge clk);
        pending_rays.push_back(known ? w : project_point(a, b, c));
        points_sent++;
    endtask

    // Random point: mostly near the horizon at random scales, some pure noise.
    task automatic random_point();
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        int                        s;
        a = COORD_W'($urandom);
        b = COORD_W'($urandom);
        c = COORD_W'($urandom);
        if ($urandom_range(0, 99) >= 20)
        begin
            s = $urandom_range(0, 18);
            a = a >>> s;
            b = b >>> s;
            c = c >>> (s + $urandom_range(2, 8));
        end
        send_point(a, b, c, 1'b0, '0);
    endtask

    // Random pose row: identity-like with a random translation, or fully random.
    function automatic logic [63:0] pose_row(int axis);
        logic [63:0] row;
        row = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0)
        begin
            row[47:0] = '0;
            row[16*axis +: 16] = 16'h4000;
            row[63:48] = $signed(row[63:48]) >>> $urandom_range(0, 12);
        end
        return row;
    endfunction

    // Output side: random stall and in-order checking of ray words.
    always @(posedge clk)
    begin
        rays.ready <= quiet || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        ray_word_t want;
        if (rst_n && rays.valid && rays.ready)
        begin
            if (pending_rays.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected ray word in_view=%0b ray_index=%0d",
                         $time, rays.in_view, rays.ray_index);
            end
            else
            begin
                want = pending_rays.pop_front();
                rays_seen++;
                if (want.in_view)
                    rays_hit++;
                if (rays.in_view !== want.in_view)
                begin
                    errors++;
                    $display("%0t: in_view expected %0b actual %0b",
                             $time, want.in_view, rays.in_view);
                end
                if (rays.ray_index !== want.ray_index)
                begin
                    errors++;
                    $display("%0t: ray_index expected %0d actual %0d",
                             $time, want.ray_index, rays.ray_index);
                end
            end
        end
    end

    // Directed points under the reset geometry.
    point_row_t directed [] = '{
        '{24'sd0, 24'sd0, 24'sd0, 1'b1, '0},
        '{24'sd0, 24'sd0, 24'sd1000, 1'b1, '0},
        '{24'sd0, 24'sd0, -24'sd8388608, 1'b1, '0},
        '{24'sd0, 24'sd0, 24'sd1, 1'b0, '0},
        '{24'sd1000, 24'sd0, 24'sd0, 1'b0, '0},
        '{-24'sd1000, 24'sd0, 24'sd0, 1'b0, '0},
        '{24'sd0, 24'sd1000, 24'sd0, 1'b0, '0},
        '{24'sd0, -24'sd1000, 24'sd0, 1'b0, '0},
        '{24'sd1, 24'sd0, 24'sd0, 1'b0, '0},
        '{-24'sd1, 24'sd0, 24'sd0, 1'b0, '0},
        '{24'sd1000, 24'sd1, 24'sd0, 1'b0, '0},
        '{24'sd1000, -24'sd1, 24'sd0, 1'b0, '0},
        '{-24'sd1000, 24'sd1, 24'sd0, 1'b0, '0},
        '{-24'sd1000, -24'sd1, 24'sd0, 1'b0, '0},
        '{24'sd5000, 24'sd0, 24'sd1300, 1'b0, '0},
        '{24'sd5000, 24'sd0, -24'sd1300, 1'b0, '0},
        '{24'sd8388607, 24'sd8388607, 24'sd0, 1'b0, '0},
        '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0, '0},
        '{24'sd8388607, -24'sd8388608, 24'sd8388607, 1'b0, '0},
        '{-24'sd8388608, 24'sd8388607, 24'sd1048576, 1'b0, '0}
    };

    // Main sequence: reset, directed points, then random phases of geometry.
    initial
    begin
        errors      = 0;
        rays_seen   = 0;
        rays_hit    = 0;
        points_sent = 0;
        quiet       = 1'b0;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        pts.valid   <= 1'b0;
        pts.px      <= '0;
        pts.py      <= '0;
        pts.pz      <= '0;
        geom.row_x       = 64'd16384;
        geom.row_y       = 64'd1073741824;
        geom.row_z       = 64'd70368744177664;
        geom.azim_step   = 16'd37;
        geom.incl_step   = 16'd364;
        geom.incl_offset = 15'd2731;
        geom.incl_rays   = 7'd16;
        geom.azim_rays   = 13'd1800;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_point(directed[i].px, directed[i].py, directed[i].pz,
                       directed[i].known, directed[i].word);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                pts.valid <= 1'b0;
                drain_pipeline();
                case (ph)
                    // Zero steps, widest offset and oversized ray counts.
                    1:
                    begin
                        write_reg(REG_ROW_X, 64'h0000_0000_0000_4000);
                        write_reg(REG_ROW_Y, 64'h0000_0000_4000_0000);
                        write_reg(REG_ROW_Z, 64'h0000_4000_0000_0000);
                        write_reg(REG_AZIM_STEP, 64'd0);
                        write_reg(REG_INCL_STEP, 64'd0);
                        write_reg(REG_INCL_OFFSET, 64'h7FFF);
                        write_reg(REG_INCL_RAYS, 64'h7F);
                        write_reg(REG_AZIM_RAYS, 64'h1FFF);
                    end
                    // Largest steps, no offset, one ray each way, extreme poses.
                    2:
                    begin
                        write_reg(REG_ROW_X, '1);
                        write_reg(REG_ROW_Y, 64'h7FFF_7FFF_7FFF_7FFF);
                        write_reg(REG_ROW_Z, 64'h8000_8000_8000_8000);
                        write_reg(REG_AZIM_STEP, 64'hFFFF);
                        write_reg(REG_INCL_STEP, 64'hFFFF);
                        write_reg(REG_INCL_OFFSET, 64'd0);
                        write_reg(REG_INCL_RAYS, 64'd1);
                        write_reg(REG_AZIM_RAYS, 64'd1);
                    end
                    // No azimuth columns: nothing is in view.
                    3:
                    begin
                        write_reg(REG_ROW_X, pose_row(0));
                        write_reg(REG_AZIM_STEP, 64'd16);
                        write_reg(REG_INCL_STEP, 64'd200);
                        write_reg(REG_INCL_OFFSET, 64'd2731);
                        write_reg(REG_INCL_RAYS, 64'd64);
                        write_reg(REG_AZIM_RAYS, 64'd0);
                    end
                    // Full-size image with random poses.
                    default:
                    begin
                        write_reg(REG_ROW_X, pose_row(0));
                        write_reg(REG_ROW_Y, pose_row(1));
                        write_reg(REG_ROW_Z, pose_row(2));
                        write_reg(REG_AZIM_STEP, 64'd16);
                        write_reg(REG_INCL_STEP, 64'(85 + $urandom_range(0, 300)));
                        write_reg(REG_INCL_OFFSET, 64'(2731 + $urandom_range(0, 200)));
                        write_reg(REG_INCL_RAYS, 64'd64);
                        write_reg(REG_AZIM_RAYS, 64'd4096);
                    end
                endcase
            end
            for (int n = 0; n < PHASE_PTS; n++)
            begin
                // A stretch with no idling on either side.
                quiet = (ph == 4 && n < 150);
                // Hold the points back once until the pipeline has emptied.
                if (ph == 0 && n == 100)
                begin
                    pts.valid <= 1'b0;
                    while (pending_rays.size() != 0)
                        @(posedge clk);
                end
                random_point();
            end
        end
        quiet = 1'b0;
        pts.valid <= 1'b0;
        drain_pipeline();

        $display("tb: %0d points sent over %0d geometries, %0d ray words checked",
                 points_sent, NUM_PHASES, rays_seen);
        $display("tb: %0d of them in view, %0d mismatches", rays_hit, errors);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/pli_pkg.sv
design/pli_if.sv
design/pli_apb.sv
design/pli_transform.sv
design/pli_cordic.sv
design/pli_divider.sv
design/point_to_lidar_ray_index.sv
verif/tb.sv
